>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define SRM_ASSERT_IMPL(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("implication check failed");

// Checks that a condition is later followed by another.
`define SRM_ASSERT_DELAY(lbl, clk, rstn, a, n, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> ##n (b)) \
    else $error("latency check failed");

`endif

>>> rtl/srm_pkg.sv
// Types, constants and helper functions of the spherical remap address unit.
`timescale 1ns / 1ps
package srm_pkg;

  localparam int CoordBits   = 10;
  localparam int CordicSteps = 16;
  localparam int SizeW       = 11;
  localparam int FracBits    = 17;
  localparam int NumW        = CoordBits + FracBits;
  localparam int CrdW        = 21;
  localparam int AngW        = 26;
  localparam int AtanW       = 22;
  localparam int WideW       = 40;
  localparam int StepIdxW    = 5;
  localparam int Latency     = NumW + CordicSteps + 4;

  localparam logic [NumW-1:0] QOne    = NumW'(65536);
  localparam logic [NumW-1:0] QSatLim = NumW'(196608);
  localparam logic signed [AngW-1:0] HalfTurn = AngW'(8388608);
  localparam logic signed [17:0] InvGain = 18'sd39797;
  localparam logic [SizeW-1:0] WidthReset  = SizeW'(256);
  localparam logic [SizeW-1:0] HeightReset = SizeW'(256);

  typedef enum logic { RegWidth = 1'b0, RegHeight = 1'b1 } reg_idx_e;

  typedef struct packed {
    logic [CoordBits-1:0] out_x;
    logic [CoordBits-1:0] out_y;
  } req_t;

  typedef struct packed {
    logic [CoordBits-1:0] src_x;
    logic [CoordBits-1:0] src_y;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic [SizeW-1:0] rem_x;
    logic [NumW-1:0]  num_x;
    logic [SizeW-1:0] rem_y;
    logic [NumW-1:0]  num_y;
  } div_t;

  typedef struct packed {
    logic                   valid;
    logic                   zero;
    logic signed [CrdW-1:0] x;
    logic signed [CrdW-1:0] y;
    logic signed [AngW-1:0] z;
  } crd_t;

  // Arctangent of 2^-i in units of 2^-24 turn.
  function automatic logic [AtanW-1:0] atan_turn(input logic [StepIdxW-1:0] i);
    logic [AtanW-1:0] v;
    unique case (i)
      5'd0:  v = AtanW'(2097152);
      5'd1:  v = AtanW'(1238021);
      5'd2:  v = AtanW'(654136);
      5'd3:  v = AtanW'(332050);
      5'd4:  v = AtanW'(166669);
      5'd5:  v = AtanW'(83416);
      5'd6:  v = AtanW'(41718);
      5'd7:  v = AtanW'(20860);
      5'd8:  v = AtanW'(10430);
      5'd9:  v = AtanW'(5215);
      5'd10: v = AtanW'(2608);
      5'd11: v = AtanW'(1304);
      5'd12: v = AtanW'(652);
      5'd13: v = AtanW'(326);
      5'd14: v = AtanW'(163);
      5'd15: v = AtanW'(81);
      5'd16: v = AtanW'(41);
      5'd17: v = AtanW'(20);
      5'd18: v = AtanW'(10);
      5'd19: v = AtanW'(5);
      5'd20: v = AtanW'(3);
      5'd21: v = AtanW'(1);
      5'd22: v = AtanW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Clamps a coordinate to 0 .. size-1 and to the coordinate range.
  function automatic logic [CoordBits-1:0] clamp_out(input logic signed [WideW-1:0] v,
                                                     input logic [SizeW-1:0] size);
    logic signed [WideW-1:0] top;
    logic signed [WideW-1:0] lim;
    logic signed [WideW-1:0] r;
    top = WideW'(size) - WideW'(1);
    lim = WideW'((1 << CoordBits) - 1);
    r = v;
    if (r < 0) r = '0;
    if (r > top) r = top;
    if (r > lim) r = lim;
    return r[CoordBits-1:0];
  endfunction

endpackage

>>> rtl/spherical_remap_address_unit.sv
// Top level of the spherical remap address unit.
//
//   Channel   Handshake                 Payload
//   command   start / busy (never high) req_i  (out_x, out_y)
//   result    done_o strobe             rsp_o  (src_x, src_y)
//   config    APB write/read            image_width @0, image_height @4
//
// One transaction is accepted every cycle; each result passes through 27
// division cells, one normalize stage, 16 CORDIC cells and three multiply
// and clamp stages.
// Reset clears every valid bit in the chain and loads both sizes with 256.
// The receiver cannot stall, so the chain never stops.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spherical_remap_address_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  srm_pkg::req_t       req_i,
  output logic                done_o,
  output srm_pkg::rsp_t       rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import srm_pkg::*;

  logic [SizeW-1:0] width_q, height_q, w_eff, h_eff;
  reg_idx_e         reg_idx;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        RegWidth:  width_q  <= pwdata[SizeW-1:0];
        RegHeight: height_q <= pwdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegWidth:  prdata = 32'(width_q);
      RegHeight: prdata = 32'(height_q);
      default:   prdata = '0;
    endcase
  end

  assign w_eff = (width_q == '0) ? SizeW'(1) : width_q;
  assign h_eff = (height_q == '0) ? SizeW'(1) : height_q;

  // Division chain: normalizes both coordinates.
  div_t div_chain [NumW+1];

  always_comb begin
    div_chain[0].valid = start && !busy;
    div_chain[0].rem_x = '0;
    div_chain[0].num_x = {req_i.out_x, FracBits'(0)};
    div_chain[0].rem_y = '0;
    div_chain[0].num_y = {req_i.out_y, FracBits'(0)};
  end

  for (genvar g = 0; g < NumW; g++) begin : g_div
    srm_div_cell u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wdiv_i (w_eff),
      .hdiv_i (h_eff),
      .d_i    (div_chain[g]),
      .d_o    (div_chain[g+1])
    );
  end

  // Normalize stage: offset, saturate and fold the left half plane.
  logic [NumW-1:0]        qx, qy;
  logic signed [CrdW-1:0] nx, ny;
  crd_t                   prep_d, prep_q;
  logic                   prep_valid_q;

  always_comb begin
    qx = div_chain[NumW].num_x;
    qy = div_chain[NumW].num_y;
    nx = (qx >= QSatLim) ? CrdW'(131071) : CrdW'(qx) - CrdW'(QOne);
    ny = (qy >= QSatLim) ? CrdW'(131071) : CrdW'(qy) - CrdW'(QOne);
    prep_d.valid = div_chain[NumW].valid;
    prep_d.zero  = (nx == '0) && (ny == '0);
    prep_d.x = nx;
    prep_d.y = ny;
    prep_d.z = '0;
    if (nx < 0) begin
      prep_d.z = (ny >= 0) ? HalfTurn : -HalfTurn;
      prep_d.x = -nx;
      prep_d.y = -ny;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else begin
      prep_valid_q <= prep_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prep_q <= prep_d;
  end

  crd_t crd_chain [CordicSteps+1];

  always_comb begin
    crd_chain[0] = prep_q;
    crd_chain[0].valid = prep_valid_q;
  end

  for (genvar g = 0; g < CordicSteps; g++) begin : g_crd
    srm_cordic_cell u_crd (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (StepIdxW'(g)),
      .c_i    (crd_chain[g]),
      .c_o    (crd_chain[g+1])
    );
  end

  // Output stages: gain correction and scaling, then clamping.
  crd_t                    fin;
  logic signed [AngW-1:0]  zsh;
  logic signed [38:0]      xg_d, xg_q;
  logic signed [37:0]      zs_d, zs_q;
  logic signed [23:0]      rr;
  logic signed [35:0]      rh_d, rh_q;
  logic [CoordBits-1:0]    sx_d, sx_q, sy_d;
  logic                    va_q, vb_q, done_q;
  rsp_t                    rsp_q;

  assign fin  = crd_chain[CordicSteps];
  assign zsh  = fin.z + HalfTurn;
  assign xg_d = 39'(fin.x) * 39'(InvGain);
  assign zs_d = 38'(zsh) * 38'($signed({1'b0, w_eff}));
  assign rr   = 24'(xg_q >>> 16);
  assign rh_d = 36'(rr) * 36'($signed({1'b0, h_eff}));
  assign sx_d = clamp_out(WideW'(zs_q >>> 24), w_eff);
  assign sy_d = clamp_out(WideW'(rh_q >>> 17), h_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      va_q   <= fin.valid;
      vb_q   <= va_q;
      done_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xg_q        <= xg_d;
    zs_q        <= zs_d;
    rh_q        <= rh_d;
    sx_q        <= sx_d;
    rsp_q.src_x <= sx_q;
    rsp_q.src_y <= sy_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `SRM_ASSERT_DELAY(a_latency, clk_i, rst_ni, (start && !busy), Latency, done_o)
  `SRM_ASSERT_IMPL(a_src_x_range, clk_i, rst_ni, done_o, ({1'b0, rsp_o.src_x} < w_eff))
  `SRM_ASSERT_IMPL(a_src_y_range, clk_i, rst_ni, done_o, ({1'b0, rsp_o.src_y} < h_eff))

endmodule

>>> rtl/srm_div_cell.sv
// One restoring division cell: yields one quotient bit for each coordinate.
`timescale 1ns / 1ps
module srm_div_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [srm_pkg::SizeW-1:0] wdiv_i,
  input  logic [srm_pkg::SizeW-1:0] hdiv_i,
  input  srm_pkg::div_t             d_i,
  output srm_pkg::div_t             d_o
);
  import srm_pkg::*;

  logic  valid_q;
  div_t  d_d, data_q;
  logic [SizeW:0] tx, ty;

  always_comb begin
    tx = {d_i.rem_x, d_i.num_x[NumW-1]};
    ty = {d_i.rem_y, d_i.num_y[NumW-1]};
    d_d = d_i;
    if (tx >= {1'b0, wdiv_i}) begin
      d_d.rem_x = SizeW'(tx - {1'b0, wdiv_i});
      d_d.num_x = {d_i.num_x[NumW-2:0], 1'b1};
    end else begin
      d_d.rem_x = tx[SizeW-1:0];
      d_d.num_x = {d_i.num_x[NumW-2:0], 1'b0};
    end
    if (ty >= {1'b0, hdiv_i}) begin
      d_d.rem_y = SizeW'(ty - {1'b0, hdiv_i});
      d_d.num_y = {d_i.num_y[NumW-2:0], 1'b1};
    end else begin
      d_d.rem_y = ty[SizeW-1:0];
      d_d.num_y = {d_i.num_y[NumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= d_d;
  end

  always_comb begin
    d_o = data_q;
    d_o.valid = valid_q;
  end

endmodule

>>> rtl/srm_cordic_cell.sv
// One CORDIC vectoring cell: a single micro-rotation per cycle.
`timescale 1ns / 1ps
module srm_cordic_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [srm_pkg::StepIdxW-1:0] step_i,
  input  srm_pkg::crd_t                c_i,
  output srm_pkg::crd_t                c_o
);
  import srm_pkg::*;

  logic valid_q;
  crd_t c_d, data_q;
  logic signed [CrdW-1:0] dx, dy;
  logic signed [AngW-1:0] da;

  always_comb begin
    dx = c_i.y >>> step_i;
    dy = c_i.x >>> step_i;
    da = AngW'(atan_turn(step_i));
    c_d = c_i;
    // The origin passes through untouched so that its angle stays zero.
    if (!c_i.zero) begin
      if (c_i.y < 0) begin
        c_d.x = c_i.x - dx;
        c_d.y = c_i.y + dy;
        c_d.z = c_i.z - da;
      end else begin
        c_d.x = c_i.x + dx;
        c_d.y = c_i.y - dy;
        c_d.z = c_i.z + da;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= c_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= c_d;
  end

  always_comb begin
    c_o = data_q;
    c_o.valid = valid_q;
  end

endmodule
